@@ design/timestamp_tag_sorted_fold_list_macros.svh @@
// Assertion macros for the sorted fold list.
// Taken in by the top level only; no dependencies.
`ifndef TIMESTAMP_TAG_SORTED_FOLD_LIST_MACROS_SVH
`define TIMESTAMP_TAG_SORTED_FOLD_LIST_MACROS_SVH

// Implication checked at every clock edge outside reset
`define TSTFL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Invariant that holds at every clock edge outside reset
`define TSTFL_ASSERT_TRUE(lbl, clk, rstn, expr, msg) \
  `TSTFL_ASSERT_IMP(lbl, clk, rstn, 1'b1, expr, msg)

`endif

@@ design/tstfl_pkg.sv @@
// Shared types, widths and helpers for the sorted fold list.
// No dependencies; used by tstfl_cell, tstfl_div and the top level.
package tstfl_pkg;

  localparam int unsigned TAG_W      = 56;
  localparam int unsigned FOLD_W     = 16;
  localparam int unsigned COARSE_W   = 48;
  localparam int unsigned FINE_W     = 22;
  localparam int unsigned COARSE_LSB = 18;  // low coarse bits are cleared
  localparam int unsigned DIVISOR_W  = 20;
  localparam int unsigned LIMIT_W    = 56;
  localparam int unsigned CFG_W      = 56;
  localparam int unsigned DIVIDEND_W = 52;  // scaled time width
  localparam int unsigned POS_W      = 8;
  localparam int unsigned USED_W     = 9;
  localparam int unsigned STATUS_W   = 2;

  localparam logic [FOLD_W-1:0] FOLD_MAX = '1;

  // Configuration register indexes
  localparam logic REG_TICK_DIVISOR = 1'b0;
  localparam logic REG_START_LIMIT  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_COUNTED  = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_CMP,
    S_UPD
  } state_e;

  // Per-cycle commands broadcast to every cell
  typedef struct packed {
    logic cmp;  // capture match and insertion point
    logic ins;  // shift right of the insertion point, write key there
    logic cnt;  // bump the fold count of the matching cell
  } cell_ctrl_t;

  // What a cell hands to its right-hand neighbor
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [FOLD_W-1:0] fold;
    logic              occ;  // entry holds a tag
    logic              gt;   // empty, or tag above the key
  } cell_link_t;

  function automatic logic [FOLD_W-1:0] fold_sat_inc(input logic [FOLD_W-1:0] f);
    return (f == FOLD_MAX) ? f : f + FOLD_W'(1);
  endfunction

endpackage

@@ design/tstfl_cell.sv @@
// One entry of the sorted tag list: tag, fold count and occupancy.
// Depends on tstfl_pkg; chained by the top level, left neighbor to right.
module tstfl_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tstfl_pkg::cell_ctrl_t       ctrl_i,
  input  logic [tstfl_pkg::TAG_W-1:0] key_i,
  input  tstfl_pkg::cell_link_t       left_i,
  output tstfl_pkg::cell_link_t       link_o,
  output logic                        hit_o,
  output logic                        ins_o
);

  logic [tstfl_pkg::TAG_W-1:0]  tag_q;
  logic [tstfl_pkg::FOLD_W-1:0] fold_q;
  logic                         occ_q;
  logic                         hit_q;
  logic                         ins_q;
  logic                         gt;
  logic                         hit;

  // Compare against the broadcast key
  assign gt  = !occ_q || (tag_q > key_i);
  assign hit = occ_q && (tag_q == key_i);

  // Occupancy and captured compare results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      hit_q <= 1'b0;
      ins_q <= 1'b0;
    end else begin
      if (ctrl_i.cmp) begin
        hit_q <= hit;
        ins_q <= gt && !left_i.gt;
      end
      if (ctrl_i.ins && gt) begin
        occ_q <= left_i.occ;
      end
    end
  end

  // Entry payload: take the key, take the left entry, or count
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins && gt) begin
      if (ins_q) begin
        tag_q  <= key_i;
        fold_q <= tstfl_pkg::FOLD_W'(1);
      end else begin
        tag_q  <= left_i.tag;
        fold_q <= left_i.fold;
      end
    end else if (ctrl_i.cnt && hit_q) begin
      fold_q <= tstfl_pkg::fold_sat_inc(fold_q);
    end
  end

  assign link_o = '{tag: tag_q, fold: fold_q, occ: occ_q, gt: gt};
  assign hit_o  = hit_q;
  assign ins_o  = ins_q;

endmodule

@@ design/tstfl_div.sv @@
// Restoring divider, one quotient bit per cycle, for the tag computation.
// Depends on tstfl_pkg for the operand widths.
module tstfl_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [tstfl_pkg::DIVIDEND_W-1:0] dividend_i,
  input  logic [tstfl_pkg::DIVISOR_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic [tstfl_pkg::DIVIDEND_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(tstfl_pkg::DIVIDEND_W);
  localparam int unsigned RW    = tstfl_pkg::DIVISOR_W;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RW-1:0]    rem_q;
  logic [RW-1:0]    dvs_q;
  logic [tstfl_pkg::DIVIDEND_W-1:0] quo_q;
  logic [RW:0]      rem_sh;
  logic [RW:0]      rem_sub;
  logic             fits;

  // One restoring step
  assign rem_sh  = {rem_q, quo_q[tstfl_pkg::DIVIDEND_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  // Step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(tstfl_pkg::DIVIDEND_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= (divisor_i == '0) ? RW'(1) : divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
      quo_q <= {quo_q[tstfl_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ design/timestamp_tag_sorted_fold_list.sv @@
// Top level of the sorted coincidence-tag list with fold counts.
// Depends on tstfl_pkg, tstfl_div, tstfl_cell and the assertion macro header.
//
//  channel   dir  handshake                tdata / tuser
//  s_axis    in   tvalid/tready            tdata[47:0] coarse_time, [69:48] fine_time
//  m_axis    out  tvalid/tready            tuser status; tdata tag, fold, pos, used
//  cfg       in   cfg_we_i, no wait        cfg_addr_i index, cfg_wdata_i value
//
// An item goes from its transfer through the divider (52 quotient bits plus the done
// handoff), then the compare state across the cell row, then the update state.
// A new item is taken the cycle after the result is loaded; none is taken while one is in flight.
// The compare cycle holds while the output register is full and not being drained.
// Reset empties the list at once through each cell's occupancy bit.
`include "timestamp_tag_sorted_fold_list_macros.svh"

module timestamp_tag_sorted_fold_list #(
  parameter int unsigned LIST_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [55:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // coarse_time[47:0], fine_time[69:48]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // time_tag[55:0], fold_count[71:56],
                                      // entry_position[79:72], entries_used[88:80]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int unsigned IW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned PW = (IW > tstfl_pkg::POS_W) ? IW : tstfl_pkg::POS_W;
  localparam int unsigned UW = (CW > tstfl_pkg::USED_W) ? CW : tstfl_pkg::USED_W;

  // Configuration registers
  logic [tstfl_pkg::DIVISOR_W-1:0] tick_div_q;
  logic [tstfl_pkg::LIMIT_W-1:0]   start_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_div_q    <= tstfl_pkg::DIVISOR_W'(1);
      start_limit_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        tstfl_pkg::REG_TICK_DIVISOR: tick_div_q    <= cfg_wdata_i[tstfl_pkg::DIVISOR_W-1:0];
        tstfl_pkg::REG_START_LIMIT:  start_limit_q <= cfg_wdata_i[tstfl_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Scaled time: masked coarse shifted up by four, fine fills the cleared bits,
  // then times ten (8x + 2x) and divided by sixteen
  logic [tstfl_pkg::FINE_W-1:0]   fine;
  logic [tstfl_pkg::COARSE_W-1:0] coarse;
  logic [51:0]                    base_x;
  logic [55:0]                    scaled_x10;
  logic [tstfl_pkg::DIVIDEND_W-1:0] dividend;

  assign coarse     = s_axis_tdata[tstfl_pkg::COARSE_W-1:0];
  assign fine       = s_axis_tdata[tstfl_pkg::COARSE_W +: tstfl_pkg::FINE_W];
  assign base_x     = {coarse[tstfl_pkg::COARSE_W-1:tstfl_pkg::COARSE_LSB], fine};
  assign scaled_x10 = {1'b0, base_x, 3'b000} + {3'b000, base_x, 1'b0};
  assign dividend   = scaled_x10[55:4];

  // Control FSM
  tstfl_pkg::state_e state_q, state_d;
  logic s_xfer;
  logic m_xfer;
  logic out_free;
  logic div_start;
  logic div_done;
  logic load_out;
  logic [tstfl_pkg::DIVIDEND_W-1:0] quot;
  tstfl_pkg::cell_ctrl_t ctrl;

  assign s_xfer   = s_axis_tvalid && s_axis_tready;
  assign m_xfer   = m_axis_tvalid && m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tstfl_pkg::S_IDLE: if (s_axis_tvalid) state_d = tstfl_pkg::S_DIV;
      tstfl_pkg::S_DIV:  if (div_done) state_d = tstfl_pkg::S_CMP;
      tstfl_pkg::S_CMP:  if (out_free) state_d = tstfl_pkg::S_UPD;
      tstfl_pkg::S_UPD:  state_d = tstfl_pkg::S_IDLE;
      default:           state_d = tstfl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tstfl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Decision for the current key
  logic                          list_empty;
  logic                          list_full;
  logic                          any_hit;
  logic                          ignore;
  tstfl_pkg::status_e            status;
  logic [CW-1:0]                 used_q;
  logic [tstfl_pkg::TAG_W-1:0]   key;

  assign key        = {{(tstfl_pkg::TAG_W - tstfl_pkg::DIVIDEND_W){1'b0}}, quot};
  assign list_empty = (used_q == '0);
  assign list_full  = (used_q == CW'(LIST_DEPTH));
  assign ignore     = list_empty && (key > start_limit_q);

  always_comb begin
    if (ignore) begin
      status = tstfl_pkg::ST_IGNORED;
    end else if (any_hit) begin
      status = tstfl_pkg::ST_COUNTED;
    end else if (list_full) begin
      status = tstfl_pkg::ST_FULL;
    end else begin
      status = tstfl_pkg::ST_INSERTED;
    end
  end

  // FSM outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    ctrl          = '0;
    unique case (state_q)
      tstfl_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        div_start     = s_axis_tvalid;
      end
      tstfl_pkg::S_DIV: ;
      tstfl_pkg::S_CMP: ctrl.cmp = 1'b1;
      tstfl_pkg::S_UPD: begin
        load_out = 1'b1;
        ctrl.ins = (status == tstfl_pkg::ST_INSERTED);
        ctrl.cnt = (status == tstfl_pkg::ST_COUNTED);
      end
      default: ;
    endcase
  end

  tstfl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (tick_div_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Row of list cells, each handing its entry to the right
  tstfl_pkg::cell_link_t link_w [LIST_DEPTH+1];
  logic [LIST_DEPTH-1:0] hit_vec;
  logic [LIST_DEPTH-1:0] ins_vec;
  logic [LIST_DEPTH-1:0] occ_vec;

  assign link_w[0] = '{tag: '0, fold: '0, occ: 1'b1, gt: 1'b0};

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    tstfl_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .key_i  (key),
      .left_i (link_w[g]),
      .link_o (link_w[g+1]),
      .hit_o  (hit_vec[g]),
      .ins_o  (ins_vec[g])
    );
    assign occ_vec[g] = link_w[g+1].occ;
  end

  // OR trees over the one-hot match and insertion flags
  logic [IW-1:0]                hit_idx;
  logic [IW-1:0]                ins_idx;
  logic [tstfl_pkg::FOLD_W-1:0] hit_fold;

  always_comb begin
    hit_idx  = '0;
    ins_idx  = '0;
    hit_fold = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      hit_idx  = hit_idx | (hit_vec[i] ? IW'(i) : '0);
      ins_idx  = ins_idx | (ins_vec[i] ? IW'(i) : '0);
      hit_fold = hit_fold | (hit_vec[i] ? link_w[i+1].fold : '0);
    end
  end

  assign any_hit = |hit_vec;

  // Result fields
  logic [tstfl_pkg::FOLD_W-1:0] res_fold;
  logic [IW-1:0]                res_idx;
  logic [CW-1:0]                res_used;
  logic [PW-1:0]                pos_wide;
  logic [UW-1:0]                used_wide;

  always_comb begin
    res_fold = '0;
    res_idx  = '0;
    res_used = used_q;
    case (status)
      tstfl_pkg::ST_IGNORED: res_used = '0;
      tstfl_pkg::ST_COUNTED: begin
        res_fold = tstfl_pkg::fold_sat_inc(hit_fold);
        res_idx  = hit_idx;
      end
      tstfl_pkg::ST_INSERTED: begin
        res_fold = tstfl_pkg::FOLD_W'(1);
        res_idx  = ins_idx;
        res_used = used_q + CW'(1);
      end
      default: ;
    endcase
  end

  assign pos_wide  = PW'(res_idx);
  assign used_wide = UW'(res_used);

  // Entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (ctrl.ins) begin
      used_q <= used_q + CW'(1);
    end
  end

  // Output register
  logic                          out_valid_q;
  tstfl_pkg::status_e            out_status_q;
  logic [tstfl_pkg::TAG_W-1:0]   out_tag_q;
  logic [tstfl_pkg::FOLD_W-1:0]  out_fold_q;
  logic [tstfl_pkg::POS_W-1:0]   out_pos_q;
  logic [tstfl_pkg::USED_W-1:0]  out_used_q;

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= status;
      out_tag_q    <= key;
      out_fold_q   <= res_fold;
      out_pos_q    <= pos_wide[tstfl_pkg::POS_W-1:0];
      out_used_q   <= used_wide[tstfl_pkg::USED_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {7'd0, out_used_q, out_pos_q, out_fold_q, out_tag_q};

  // Checks
  `TSTFL_ASSERT_TRUE(a_hit_onehot, clk_i, rst_ni, $onehot0(hit_vec), "tag matched in two cells")
  `TSTFL_ASSERT_TRUE(a_ins_onehot, clk_i, rst_ni, $onehot0(ins_vec), "two insertion points")
  `TSTFL_ASSERT_TRUE(a_occ_count, clk_i, rst_ni, $countones(occ_vec) == used_q, "occupancy off")
  `TSTFL_ASSERT_IMP(a_upd_out_free, clk_i, rst_ni, load_out, !out_valid_q, "output register busy")

  // Input transfer is what starts the divider
  `TSTFL_ASSERT_IMP(a_start_on_xfer, clk_i, rst_ni, div_start, s_xfer, "start without transfer")

endmodule

@@ test/tb_top.sv @@
// Testbench for the sorted coincidence-tag list with fold counts: random and directed
// fragments, a predictor of the list and a field-by-field result check.
// Depends on tstfl_pkg and the timestamp_tag_sorted_fold_list top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Widths from the package
  localparam int unsigned COARSE_W   = tstfl_pkg::COARSE_W;
  localparam int unsigned FINE_W     = tstfl_pkg::FINE_W;
  localparam int unsigned COARSE_LSB = tstfl_pkg::COARSE_LSB;
  localparam int unsigned TAG_W      = tstfl_pkg::TAG_W;
  localparam int unsigned FOLD_W     = tstfl_pkg::FOLD_W;
  localparam int unsigned POS_W      = tstfl_pkg::POS_W;
  localparam int unsigned USED_W     = tstfl_pkg::USED_W;
  localparam int unsigned DIVISOR_W  = tstfl_pkg::DIVISOR_W;
  localparam int unsigned LIMIT_W    = tstfl_pkg::LIMIT_W;
  localparam int unsigned CFG_W      = tstfl_pkg::CFG_W;

  localparam int unsigned LIST_DEPTH   = 256;
  localparam int unsigned NS_SCALE_NUM = 10;
  localparam int unsigned NS_SCALE_DEN = 16;
  localparam int unsigned PHASE_FRAGS  = 240;
  localparam int unsigned DRAIN_CYCLES = 70;  // idle clocks after draining, before the final check
  localparam logic [COARSE_W-1:0] COARSE_KEEP = {COARSE_W{1'b1}} << COARSE_LSB;

  typedef struct packed {
    logic [FINE_W-1:0]   fine;
    logic [COARSE_W-1:0] coarse;
  } fragment_t;

  typedef struct packed {
    tstfl_pkg::status_e  status;
    logic [TAG_W-1:0]    tag;
    logic [FOLD_W-1:0]   fold;
    logic [POS_W-1:0]    pos;
    logic [USED_W-1:0]   used;
  } fold_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_addr_i = 1'b0;
  logic [55:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  timestamp_tag_sorted_fold_list #(
    .LIST_DEPTH(LIST_DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // coarse_time[47:0], fine_time[69:48]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // time_tag, fold_count, entry_position, entries_used
    .m_axis_tuser  (m_axis_tuser)    // status
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: register copies and the sorted list
  logic [DIVISOR_W-1:0] tick_div_reg = DIVISOR_W'(1);
  logic [LIMIT_W-1:0]   start_limit_reg = '1;
  logic [TAG_W-1:0]     list_tags [LIST_DEPTH];
  logic [FOLD_W-1:0]    list_folds [LIST_DEPTH];
  int unsigned          list_fill = 0;
  int unsigned          peak_fill = 0;

  fragment_t    pending_frags[$];
  fragment_t    phase_frags[$];
  fold_result_t tag_results_due[$];
  int unsigned  frags_issued = 0;
  int unsigned  frags_accepted = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  status_tally [4] = '{0, 0, 0, 0};
  logic [COARSE_W-1:0] phase_base = '0;

  // Nanosecond time, scaled by 10/16, then divided into coincidence ticks
  function automatic logic [TAG_W-1:0] fold_time_tag(input logic [COARSE_W-1:0] coarse,
                                                     input logic [FINE_W-1:0] fine,
                                                     input logic [DIVISOR_W-1:0] divisor);
    logic [63:0] ns_time;
    logic [63:0] ticks;
    ns_time = (64'(coarse & COARSE_KEEP) << 4) + 64'(fine);
    ns_time = ns_time * 64'(NS_SCALE_NUM) / 64'(NS_SCALE_DEN);
    ticks = ns_time / ((divisor == '0) ? 64'd1 : 64'(divisor));
    return ticks[TAG_W-1:0];
  endfunction

  // Apply one fragment to the list copy and return the result it must produce
  function automatic fold_result_t fold_fragment(input fragment_t frag);
    fold_result_t res;
    int unsigned i;
    int unsigned slot;
    res.tag = fold_time_tag(frag.coarse, frag.fine, tick_div_reg);
    res.fold = '0;
    res.pos = '0;
    res.used = USED_W'(list_fill);
    if (list_fill == 0 && res.tag > start_limit_reg) begin
      res.status = tstfl_pkg::ST_IGNORED;
      return res;
    end
    for (i = 0; i < list_fill; i++) begin
      if (list_tags[i] == res.tag) begin
        if (list_folds[i] != tstfl_pkg::FOLD_MAX) list_folds[i] = list_folds[i] + 1'b1;
        res.status = tstfl_pkg::ST_COUNTED;
        res.fold = list_folds[i];
        res.pos = POS_W'(i);
        return res;
      end
    end
    if (list_fill >= LIST_DEPTH) begin
      res.status = tstfl_pkg::ST_FULL;
      return res;
    end
    slot = 0;
    while (slot < list_fill && list_tags[slot] < res.tag) slot++;
    for (i = list_fill; i > slot; i--) begin
      list_tags[i] = list_tags[i-1];
      list_folds[i] = list_folds[i-1];
    end
    list_tags[slot] = res.tag;
    list_folds[slot] = FOLD_W'(1);
    list_fill++;
    if (list_fill > peak_fill) peak_fill = list_fill;
    res.status = tstfl_pkg::ST_INSERTED;
    res.fold = FOLD_W'(1);
    res.pos = POS_W'(slot);
    res.used = USED_W'(list_fill);
    return res;
  endfunction

  // Sender: bursts of random length, random gaps after each burst
  int unsigned burst_left = 1;
  int unsigned idle_gap = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (idle_gap > 0 || pending_frags.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (idle_gap > 0) idle_gap--;
      end else begin
        s_axis_tdata <= {2'b00, pending_frags.pop_front()};
        s_axis_tvalid <= 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          idle_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
        end
      end
    end
  end

  // Receiver: rotating ready pattern, swapped now and then, sometimes always ready
  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned pattern_age = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (pattern_age == 0) begin
        ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        pattern_age = $urandom_range(40, 300);
      end else begin
        pattern_age--;
        ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
      end
      m_axis_tready <= ready_pattern[0];
    end
  end

  // Check results first, then predict for a fragment taken on the same edge
  always @(posedge clk_i) begin
    fold_result_t got;
    fold_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = tstfl_pkg::status_e'(m_axis_tuser);
      got.tag = m_axis_tdata[55:0];
      got.fold = m_axis_tdata[71:56];
      got.pos = m_axis_tdata[79:72];
      got.used = m_axis_tdata[88:80];
      status_tally[got.status]++;
      if (tag_results_due.size() == 0) begin
        $error("unexpected result transfer: status %0d tag %0h", got.status, got.tag);
        mismatch_count++;
      end else begin
        want = tag_results_due.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatch_count++;
        end
        if (got.tag !== want.tag) begin
          $error("time_tag: expected %0h, got %0h", want.tag, got.tag);
          mismatch_count++;
        end
        if (got.fold !== want.fold) begin
          $error("fold_count: expected %0d, got %0d", want.fold, got.fold);
          mismatch_count++;
        end
        if (got.pos !== want.pos) begin
          $error("entry_position: expected %0d, got %0d", want.pos, got.pos);
          mismatch_count++;
        end
        if (got.used !== want.used) begin
          $error("entries_used: expected %0d, got %0d", want.used, got.used);
          mismatch_count++;
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      tag_results_due.push_back(fold_fragment(fragment_t'(s_axis_tdata[69:0])));
      frags_accepted++;
    end
  end

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tstfl_pkg::REG_TICK_DIVISOR) tick_div_reg = value[DIVISOR_W-1:0];
    else start_limit_reg = value[LIMIT_W-1:0];
  endtask

  task automatic queue_fragment(input logic [COARSE_W-1:0] coarse,
                                input logic [FINE_W-1:0] fine);
    fragment_t f;
    f.coarse = coarse;
    f.fine = fine;
    pending_frags.push_back(f);
    phase_frags.push_back(f);
    frags_issued++;
  endtask

  // Hold off until every queued fragment has been taken and answered
  task automatic wait_drained();
    while (frags_accepted != frags_issued || tag_results_due.size() != 0) @(posedge clk_i);
  endtask

  // Random fragment: often a repeat from this phase, else one of a few time shapes
  task automatic queue_random_fragment(input int unsigned repeat_pct);
    fragment_t f;
    logic [63:0] r;
    if (phase_frags.size() != 0 && $urandom_range(0, 99) < repeat_pct) begin
      f = phase_frags[$urandom_range(0, phase_frags.size() - 1)];
    end else begin
      r = {$urandom, $urandom};
      f.fine = FINE_W'($urandom);
      case ($urandom_range(0, 3))
        0: f.coarse = r[COARSE_W-1:0];
        1: f.coarse = COARSE_W'($urandom_range(0, 32'h00FF_FFFF));
        2: f.coarse = phase_base + COARSE_W'($urandom_range(0, 32'h000F_FFFF));
        default: begin
          f.coarse = r[0] ? '1 : COARSE_W'(r[17:1]);
          if (r[18]) f.fine = '1;
        end
      endcase
    end
    queue_fragment(f.coarse, f.fine);
  endtask

  initial begin
    logic [TAG_W-1:0] probe_tag;
    logic [19:0] divisor_plan [6];
    int unsigned ph;
    divisor_plan = '{20'd1, 20'd0, 20'hFFFFF, 20'd37, 20'd10, 20'd0};
    divisor_plan[5] = 20'($urandom);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty list: every tag above a zero limit is dropped, divisor 0 acts as 1
    write_reg(tstfl_pkg::REG_TICK_DIVISOR, '0);
    write_reg(tstfl_pkg::REG_START_LIMIT, '0);
    queue_fragment('1, '1);
    queue_fragment('0, FINE_W'(2));
    queue_fragment(COARSE_W'(18'h3FFFF), '1);
    wait_drained();

    // Start limit boundary: one above is dropped, equal is taken
    probe_tag = fold_time_tag(48'h1234_5678_9ABC, 22'h2AAAAA, '0);
    write_reg(tstfl_pkg::REG_START_LIMIT, CFG_W'(probe_tag - 1'b1));
    queue_fragment(48'h1234_5678_9ABC, 22'h2AAAAA);
    wait_drained();
    write_reg(tstfl_pkg::REG_START_LIMIT, CFG_W'(probe_tag));
    queue_fragment(48'h1234_5678_9ABC, 22'h2AAAAA);
    wait_drained();

    // Insert at front, middle and end; masked coarse bits land on an existing tag
    write_reg(tstfl_pkg::REG_START_LIMIT, '1);
    write_reg(tstfl_pkg::REG_TICK_DIVISOR, CFG_W'(1));
    queue_fragment('0, '0);
    queue_fragment(COARSE_W'(18'h3FFFF), '0);
    queue_fragment('1, '1);
    queue_fragment(48'h1234_5678_9ABC, 22'h2AAAAA);
    queue_fragment('0, '1);
    queue_fragment('0, '1);
    wait_drained();

    // Largest divisor
    write_reg(tstfl_pkg::REG_TICK_DIVISOR, CFG_W'(20'hFFFFF));
    queue_fragment('1, '1);
    queue_fragment('0, '1);
    queue_fragment('0, '0);
    queue_fragment('1, '0);

    // Random phases, one divisor setting each; the list fills early on
    for (ph = 0; ph < 6; ph++) begin
      wait_drained();
      phase_frags.delete();
      phase_base = COARSE_W'({$urandom, $urandom});
      write_reg(tstfl_pkg::REG_TICK_DIVISOR, CFG_W'(divisor_plan[ph]));
      case (ph)
        0: write_reg(tstfl_pkg::REG_START_LIMIT, '0);
        1: write_reg(tstfl_pkg::REG_START_LIMIT, '1);
        default: write_reg(tstfl_pkg::REG_START_LIMIT, CFG_W'({$urandom, $urandom}));
      endcase
      repeat (PHASE_FRAGS) queue_random_fragment((ph < 2) ? 30 : 50);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tag_results_due.size() != 0) begin
      $error("%0d results never arrived", tag_results_due.size());
      mismatch_count++;
    end
    $display("tb_top: %0d fragments over 6 divisor settings: %0d inserted, %0d counted,",
             frags_issued, status_tally[tstfl_pkg::ST_INSERTED],
             status_tally[tstfl_pkg::ST_COUNTED]);
    $display("tb_top: %0d dropped on a full list, %0d dropped while empty, peak fill %0d/%0d",
             status_tally[tstfl_pkg::ST_FULL], status_tally[tstfl_pkg::ST_IGNORED],
             peak_fill, LIST_DEPTH);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #(20_000_000);
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
